// ===== rtl/pcx_pkg.sv =====
// shared types, constants and codes of the run-length planar decoder
`default_nettype none

package pcx_pkg;

    // line store depth default
    localparam int DEF_MAX_LINE_BYTES = 512;

    // register field widths
    localparam int MODE_W       = 3;
    localparam int WIDTH_W      = 13;
    localparam int HEIGHT_W     = 17;
    localparam int LINE_BYTES_W = 10;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;

    localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_MODE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_BYTES   = 3'd3;

    // pixel modes
    localparam logic [MODE_W-1:0] MODE_LAST_PLANAR = 3'd3;
    localparam logic [MODE_W-1:0] MODE_8BIT        = 3'd4;
    localparam logic [MODE_W-1:0] MODE_24BIT       = 3'd5;

    // coded byte fields
    localparam logic [7:0] MARKER_MASK = 8'hC0;
    localparam logic [7:0] RUN_MASK    = 8'h3F;

    // widest row that is kept
    localparam logic [WIDTH_W-1:0] MAX_KEPT_WIDTH = 13'd4096;

    // planes held in the line store (all but the last of four)
    localparam int STORED_PLANES = 3;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // classified item: a byte and how many times it is placed
    typedef struct packed {
        logic [7:0] code_byte;
        logic [5:0] count;
        logic       frame_start;
    } pcx_item_t;

    // one decoded pixel group
    typedef struct packed {
        logic [15:0] row;
        logic [11:0] column;
        logic [1:0]  plane_index;
        logic [31:0] pixels;
        logic [3:0]  pixel_count;
        logic        run_last;
        logic        frame_end;
    } pcx_result_t;

    // back end sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_PLACE,
        ST_FLUSH
    } pcx_state_t;

endpackage

`default_nettype wire

// ===== rtl/pcx_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module pcx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pcx_queue.sv =====
// short queue of classified items between front and back
`default_nettype none

module pcx_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire pcx_pkg::pcx_item_t push_item,
    output logic                   full,
    input  wire logic              pop,
    output logic                   head_valid,
    output pcx_pkg::pcx_item_t     head_item
);
    import pcx_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    pcx_item_t         slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // pointer and fill level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // item storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    // fill level never passes the depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue fill level beyond depth");

endmodule

`default_nettype wire

// ===== rtl/pcx_front.sv =====
// front end: takes coded bytes and turns markers and literals into placement items
`default_nettype none

module pcx_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [7:0]        code_byte,
    input  wire logic              frame_start,
    input  wire logic              queue_full,
    output logic                   push,
    output pcx_pkg::pcx_item_t     push_item
);
    import pcx_pkg::*;

    logic       run_pending_reg, run_pending_next;
    logic [5:0] run_length_reg, run_length_next;
    logic       accept;
    logic       pending_now;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;

    // classify the byte against the run state
    always_comb
    begin
        run_pending_next      = run_pending_reg;
        run_length_next       = run_length_reg;
        pending_now           = run_pending_reg && !frame_start;
        push_item.code_byte   = code_byte;
        push_item.frame_start = frame_start;
        push_item.count       = 6'd0;
        if (pending_now)
        begin
            push_item.count = run_length_reg;
        end
        else if ((code_byte & MARKER_MASK) == MARKER_MASK)
        begin
            push_item.count = 6'd0;
        end
        else
        begin
            push_item.count = 6'd1;
        end
        push = accept && (frame_start || push_item.count != 6'd0);
        if (accept)
        begin
            if (pending_now)
            begin
                run_pending_next = 1'b0;
            end
            else if ((code_byte & MARKER_MASK) == MARKER_MASK)
            begin
                run_pending_next = 1'b1;
                run_length_next  = 6'(code_byte & RUN_MASK);
            end
            else
            begin
                run_pending_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_pending_reg <= 1'b0;
            run_length_reg  <= '0;
        end
        else
        begin
            run_pending_reg <= run_pending_next;
            run_length_reg  <= run_length_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pcx_back.sv =====
// back end: places bytes by row, plane and column and builds pixel groups
`default_nettype none

module pcx_back #(
    parameter int MAX_LINE_BYTES = pcx_pkg::DEF_MAX_LINE_BYTES
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic [pcx_pkg::MODE_W-1:0]       pixel_mode,
    input  wire logic [pcx_pkg::WIDTH_W-1:0]      image_width,
    input  wire logic [pcx_pkg::HEIGHT_W-1:0]     image_height,
    input  wire logic [pcx_pkg::LINE_BYTES_W-1:0] line_bytes,
    input  wire logic                             queue_valid,
    input  wire pcx_pkg::pcx_item_t               queue_item,
    output logic                                  queue_pop,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output pcx_pkg::pcx_result_t                  out_result
);
    import pcx_pkg::*;

    localparam int COL_W = $clog2(MAX_LINE_BYTES);
    localparam int LB_W  = $clog2(MAX_LINE_BYTES + 1);
    localparam int LBC_W = (LB_W > LINE_BYTES_W) ? LB_W : LINE_BYTES_W;
    localparam int PX_W  = ((COL_W + 3) > WIDTH_W) ? (COL_W + 3) : WIDTH_W;

    // control state
    pcx_state_t         state_reg, state_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [1:0]         plane_reg, plane_next;
    logic [HEIGHT_W-1:0] row_reg, row_next;
    logic [5:0]         rem_reg, rem_next;
    logic               hold_vld_reg, hold_vld_next;
    logic               out_valid_reg, out_valid_next;

    // payload
    logic [7:0]         byte_reg, byte_next;
    pcx_result_t        hold_reg, hold_next;
    pcx_result_t        out_data_reg;
    pcx_result_t        out_mux;
    logic               out_load;

    // line store
    logic                     ram_re;
    logic [COL_W-1:0]         ram_raddr;
    logic [STORED_PLANES-1:0] ram_we;
    logic [7:0]               plane_rd [STORED_PLANES];
    logic [31:0]              stored;

    // placement datapath
    logic [1:0]          last_plane, cur_plane;
    logic [LBC_W-1:0]    lb_ext;
    logic [LB_W-1:0]     lb, col_inc;
    logic [WIDTH_W-1:0]  ew;
    logic [PX_W-1:0]     px, diff;
    logic [3:0]          cnt;
    logic                planar, pl_active, pl_emit, line_done, in_width, px_end;
    logic [31:0]         pix;
    pcx_result_t         pl_result;
    logic [COL_W-1:0]    pl_col;
    logic [1:0]          pl_plane;
    logic [HEIGHT_W-1:0] pl_row;
    logic [STORED_PLANES-1:0] pl_we;
    logic                out_free, last_one, need_out, commit;

    genvar k;
    generate
        for (k = 0; k < STORED_PLANES; k++)
        begin : g_plane
            pcx_ram #(
                .WIDTH (8),
                .DEPTH (MAX_LINE_BYTES)
            ) u_ram (
                .clk   (clk),
                .we    (ram_we[k]),
                .waddr (col_reg),
                .wdata (byte_reg),
                .re    (ram_re),
                .raddr (ram_raddr),
                .rdata (plane_rd[k])
            );
        end
    endgenerate

    assign stored = {8'h00, plane_rd[2], plane_rd[1], plane_rd[0]};

    // one placement of byte_reg at the current row, plane and column
    always_comb
    begin
        planar = (pixel_mode <= MODE_LAST_PLANAR);
        if (planar)
        begin
            last_plane = pixel_mode[1:0];
        end
        else if (pixel_mode == MODE_8BIT)
        begin
            last_plane = 2'd0;
        end
        else
        begin
            last_plane = 2'd2;
        end
        cur_plane = (plane_reg > last_plane) ? last_plane : plane_reg;

        // clamp the line length and the kept width
        lb_ext = LBC_W'(line_bytes);
        if (line_bytes == '0)
        begin
            lb = LB_W'(1);
        end
        else if (lb_ext > LBC_W'(MAX_LINE_BYTES))
        begin
            lb = LB_W'(MAX_LINE_BYTES);
        end
        else
        begin
            lb = lb_ext[LB_W-1:0];
        end
        ew = (image_width > MAX_KEPT_WIDTH) ? MAX_KEPT_WIDTH : image_width;

        col_inc   = LB_W'(col_reg) + LB_W'(1);
        line_done = (col_inc >= lb);
        pl_active = (pixel_mode <= MODE_24BIT) && (row_reg < image_height);

        px       = planar ? PX_W'({col_reg, 3'b000}) : PX_W'(col_reg);
        in_width = (px < PX_W'(ew));
        diff     = PX_W'(ew) - px;
        if (!planar)
        begin
            cnt = 4'd1;
        end
        else if (diff < PX_W'(8))
        begin
            cnt = diff[3:0];
        end
        else
        begin
            cnt = 4'd8;
        end
        px_end = ((PX_W + 1)'(px) + (PX_W + 1)'(cnt)) >= (PX_W + 1)'(ew);

        // gather plane bits into eight 4-bit pixels, first pixel on top
        pix = '0;
        for (int i = 0; i < 8; i++)
        begin
            for (int q = 0; q < 4; q++)
            begin
                if (q < STORED_PLANES && q < int'(last_plane))
                begin
                    pix[28 - 4 * i + q] = stored[8 * q + 7 - i];
                end
                else if (q == int'(last_plane))
                begin
                    pix[28 - 4 * i + q] = byte_reg[7 - i];
                end
            end
        end

        pl_emit = pl_active && in_width && (!planar || cur_plane == last_plane);

        pl_result.row         = row_reg[15:0];
        pl_result.column      = px[11:0];
        pl_result.plane_index = (pixel_mode == MODE_24BIT) ? cur_plane : 2'd0;
        pl_result.pixels      = planar ? pix : {24'h000000, byte_reg};
        pl_result.pixel_count = cnt;
        pl_result.run_last    = 1'b0;
        pl_result.frame_end   = (cur_plane == last_plane)
                                && ((HEIGHT_W + 1)'(row_reg) + 1'b1
                                    == (HEIGHT_W + 1)'(image_height))
                                && (px_end || line_done);

        // earlier planes go to the line store
        pl_we = '0;
        if (pl_active && planar && cur_plane < last_plane)
        begin
            pl_we[cur_plane] = 1'b1;
        end

        // advance column, plane and row
        pl_col   = col_reg;
        pl_plane = plane_reg;
        pl_row   = row_reg;
        if (pl_active)
        begin
            if (line_done)
            begin
                pl_col = '0;
                if (cur_plane == last_plane)
                begin
                    pl_plane = 2'd0;
                    pl_row   = row_reg + 1'b1;
                end
                else
                begin
                    pl_plane = cur_plane + 2'd1;
                end
            end
            else
            begin
                pl_col = col_inc[COL_W-1:0];
            end
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign last_one = (rem_reg == 6'd1);
    assign need_out = (pl_emit && hold_vld_reg) || (last_one && (pl_emit || hold_vld_reg));
    assign commit   = !need_out || out_free;

    // sequencer: pop, read line store, place, flush held group
    always_comb
    begin
        state_next    = state_reg;
        col_next      = col_reg;
        plane_next    = plane_reg;
        row_next      = row_reg;
        rem_next      = rem_reg;
        hold_vld_next = hold_vld_reg;
        byte_next     = byte_reg;
        hold_next     = hold_reg;
        queue_pop     = 1'b0;
        ram_re        = 1'b0;
        ram_raddr     = col_reg;
        ram_we        = '0;
        out_load      = 1'b0;
        out_mux       = hold_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (queue_valid)
                begin
                    queue_pop = 1'b1;
                    byte_next = queue_item.code_byte;
                    rem_next  = queue_item.count;
                    ram_re    = 1'b1;
                    if (queue_item.frame_start)
                    begin
                        col_next   = '0;
                        plane_next = 2'd0;
                        row_next   = '0;
                        ram_raddr  = '0;
                    end
                    if (queue_item.count != 6'd0)
                    begin
                        state_next = ST_PLACE;
                    end
                end
            end
            ST_READ:
            begin
                ram_re     = 1'b1;
                state_next = ST_PLACE;
            end
            ST_PLACE:
            begin
                if (commit)
                begin
                    ram_we     = pl_we;
                    col_next   = pl_col;
                    plane_next = pl_plane;
                    row_next   = pl_row;
                    rem_next   = rem_reg - 6'd1;
                    state_next = last_one ? ST_IDLE : ST_READ;
                    if (pl_emit && hold_vld_reg)
                    begin
                        // older group leaves, new one waits for the run to end
                        out_load         = 1'b1;
                        out_mux          = hold_reg;
                        out_mux.run_last = 1'b0;
                        hold_next        = pl_result;
                        if (last_one)
                        begin
                            state_next = ST_FLUSH;
                        end
                    end
                    else if (pl_emit)
                    begin
                        if (last_one)
                        begin
                            out_load         = 1'b1;
                            out_mux          = pl_result;
                            out_mux.run_last = 1'b1;
                        end
                        else
                        begin
                            hold_next     = pl_result;
                            hold_vld_next = 1'b1;
                        end
                    end
                    else if (hold_vld_reg && last_one)
                    begin
                        out_load         = 1'b1;
                        out_mux          = hold_reg;
                        out_mux.run_last = 1'b1;
                        hold_vld_next    = 1'b0;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_load         = 1'b1;
                    out_mux          = hold_reg;
                    out_mux.run_last = 1'b1;
                    hold_vld_next    = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            plane_reg     <= 2'd0;
            row_reg       <= '0;
            rem_reg       <= '0;
            hold_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            plane_reg     <= plane_next;
            row_reg       <= row_next;
            rem_reg       <= rem_next;
            hold_vld_reg  <= hold_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        hold_reg <= hold_next;
        if (out_load)
        begin
            out_data_reg <= out_mux;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_data_reg;

    // no held group is left over between transactions
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !hold_vld_reg)
        else $error("held group left while idle");

    // placements only run with work remaining
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ || state_reg == ST_PLACE) |-> rem_reg != 6'd0)
        else $error("placement with no repeat left");

    // flush only happens with a held group
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FLUSH |-> hold_vld_reg)
        else $error("flush without held group");

    // a new group never overwrites one still waiting at the output
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("output overwritten while stalled");

endmodule

`default_nettype wire

// ===== rtl/pcx_rle_planar_decoder.sv =====
// top level of the run-length planar image decoder
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------------------
//  in      | in        | in_valid / in_stall     | code_byte, frame_start
//  out     | out       | out_valid / out_stall   | row, column, plane_index, pixels,
//          |           |                         | pixel_count, run_last, frame_end
//  cfg     | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// a marker byte sends no item on from the front end unless it starts a frame. each
// placement of a byte in the back end is a line store read, then a place; a literal is
// placed once and a run n times, with a flush when a run's last group is held back.
// a two-entry queue lets the front take bytes while the back expands a run.
// reset (rst_n low) clears row, column, plane, run state and the registers to their
// defaults; the line store is not cleared. a stalled output holds its group while the
// back end keeps placing until a second group needs the output.
`default_nettype none

module pcx_rle_planar_decoder #(
    parameter int MAX_LINE_BYTES = pcx_pkg::DEF_MAX_LINE_BYTES
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // coded bytes
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [7:0]                      code_byte,
    input  wire logic                            frame_start,
    // pixel groups
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [15:0]                          row,
    output logic [11:0]                          column,
    output logic [1:0]                           plane_index,
    output logic [31:0]                          pixels,
    output logic [3:0]                           pixel_count,
    output logic                                 run_last,
    output logic                                 frame_end,
    // register writes
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [pcx_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [pcx_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pcx_pkg::*;

    logic [MODE_W-1:0]       pixel_mode_reg;
    logic [WIDTH_W-1:0]      image_width_reg;
    logic [HEIGHT_W-1:0]     image_height_reg;
    logic [LINE_BYTES_W-1:0] line_bytes_reg;

    logic        push, queue_full, queue_valid, queue_pop;
    pcx_item_t   push_item, queue_item;
    pcx_result_t out_result;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_mode_reg   <= '0;
            image_width_reg  <= WIDTH_W'(1);
            image_height_reg <= HEIGHT_W'(1);
            line_bytes_reg   <= LINE_BYTES_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PIXEL_MODE:   pixel_mode_reg   <= cfg_data[MODE_W-1:0];
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[HEIGHT_W-1:0];
                CFG_LINE_BYTES:   line_bytes_reg   <= cfg_data[LINE_BYTES_W-1:0];
                default:          ;
            endcase
        end
    end

    pcx_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .code_byte   (code_byte),
        .frame_start (frame_start),
        .queue_full  (queue_full),
        .push        (push),
        .push_item   (push_item)
    );

    pcx_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (queue_pop),
        .head_valid (queue_valid),
        .head_item  (queue_item)
    );

    pcx_back #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_mode   (pixel_mode_reg),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .line_bytes   (line_bytes_reg),
        .queue_valid  (queue_valid),
        .queue_item   (queue_item),
        .queue_pop    (queue_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_result   (out_result)
    );

    // result fields to ports
    assign row         = out_result.row;
    assign column      = out_result.column;
    assign plane_index = out_result.plane_index;
    assign pixels      = out_result.pixels;
    assign pixel_count = out_result.pixel_count;
    assign run_last    = out_result.run_last;
    assign frame_end   = out_result.frame_end;

endmodule

`default_nettype wire
